[hdl/page_framebuffer_pixel_plot_macros.svh]
// Assertion macros for the page-mode frame store pixel plotter.
// Taken in by the top level; needs no other file.
`ifndef PAGE_FRAMEBUFFER_PIXEL_PLOT_MACROS_SVH
`define PAGE_FRAMEBUFFER_PIXEL_PLOT_MACROS_SVH

// antecedent and consequent in the same cycle
`define PFP_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("pixel plot check failed");

// consequent in the following cycle
`define PFP_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("pixel plot check failed");

`define PFP_ASSERT_TWO(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##2 (cons)) \
    else $error("pixel plot check failed");

`endif

[hdl/pfp_pkg.sv]
// Package for the page-mode frame store pixel plotter: word types,
// register indexes, step codes and the microcode table. No dependencies.
`timescale 1ns / 1ps

package pfp_pkg;

  localparam int DEF_COLUMNS = 128;
  localparam int DEF_ROWS    = 32;

  typedef struct packed {
    logic       action;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic       colour;
  } item_t;

  typedef struct packed {
    logic       is_data;
    logic [7:0] byte_value;
    logic       last;
  } result_t;

  localparam logic       ACT_PLOT  = 1'b0;
  localparam logic       ACT_CLEAR = 1'b1;

  localparam logic [1:0] REG_PAGE_BASE = 2'd0;
  localparam logic [1:0] REG_LOW_BASE  = 2'd1;
  localparam logic [1:0] REG_HIGH_BASE = 2'd2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_WRITE = 3'd1;
  localparam logic [2:0] ST_LOW   = 3'd2;
  localparam logic [2:0] ST_HIGH  = 3'd3;
  localparam logic [2:0] ST_DATA  = 3'd4;
  localparam logic [2:0] ST_CLEAR = 3'd5;

  typedef enum logic [1:0] {
    J_NEXT  = 2'd0,
    J_WAIT  = 2'd1,
    J_HOME  = 2'd2,
    J_CLEAR = 2'd3
  } jump_t;

  typedef enum logic [1:0] {
    SEL_PAGE = 2'd0,
    SEL_LOW  = 2'd1,
    SEL_HIGH = 2'd2,
    SEL_DATA = 2'd3
  } byte_sel_t;

  typedef struct packed {
    logic      emit;
    byte_sel_t sel;
    logic      is_data;
    logic      last;
    logic      mem_wr;
    logic      clr_wr;
    jump_t     cond;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [2:0] step);
    ctrl_t w;
    w = '0;
    w.cond = J_HOME;
    unique case (step)
      ST_IDLE: begin
        w.cond = J_WAIT;
      end
      ST_WRITE: begin
        w.mem_wr = 1'b1;
        w.emit   = 1'b1;
        w.sel    = SEL_PAGE;
        w.cond   = J_NEXT;
      end
      ST_LOW: begin
        w.emit = 1'b1;
        w.sel  = SEL_LOW;
        w.cond = J_NEXT;
      end
      ST_HIGH: begin
        w.emit = 1'b1;
        w.sel  = SEL_HIGH;
        w.cond = J_NEXT;
      end
      ST_DATA: begin
        w.emit    = 1'b1;
        w.sel     = SEL_DATA;
        w.is_data = 1'b1;
        w.last    = 1'b1;
        w.cond    = J_HOME;
      end
      ST_CLEAR: begin
        w.clr_wr = 1'b1;
        w.cond   = J_CLEAR;
      end
      default: begin
        w.cond = J_HOME;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/page_framebuffer_pixel_plot.sv]
// Page-mode frame store pixel plotter, top level.
// Depends on pfp_pkg and page_framebuffer_pixel_plot_macros.svh.
//
// Usage: drive item and raise start; the word is taken at a clock edge where
// start is high and busy is low. A plot word inside the panel reads the store
// byte, sets or clears the pixel bit and writes it back, then emits four
// words on result, each marked by strobe for one cycle: page command, low
// column command, high column command, and the new data byte with last set.
// The first word is registered onto result from the write-back step; a plot item
// passes through the steps accept, write back with page command and three more
// emits, set by the microcode program of one step a cycle and the single store port.
// A plot outside the panel is accepted, leaves the plotter idle and emits nothing.
// A clear word walks the store, one byte a cycle, over all COLUMNS * ceil(ROWS / 8)
// bytes, busy throughout, and emits nothing.
// Reset runs the same clearing pass and loads the command bases; register
// writes on cfg_we are taken in any cycle outside reset.
// The receiver cannot stall: every result word is shown for one cycle only.
`timescale 1ns / 1ps
`include "page_framebuffer_pixel_plot_macros.svh"

module page_framebuffer_pixel_plot #(
  parameter int COLUMNS = pfp_pkg::DEF_COLUMNS,
  parameter int ROWS    = pfp_pkg::DEF_ROWS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  pfp_pkg::item_t  item,
  output logic            busy,
  output logic            strobe,
  output pfp_pkg::result_t result,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_idx,
  input  logic [7:0]      cfg_data
);
  import pfp_pkg::*;

  localparam int PAGES = (ROWS + 7) / 8;
  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  logic [7:0]    page_base;
  logic [7:0]    low_base;
  logic [7:0]    high_base;

  logic [2:0]    step;
  logic [2:0]    step_next;
  ctrl_t         cw;

  logic [7:0]    store [DEPTH];
  logic [7:0]    rd_q;
  logic [AW-1:0] addr_q;
  logic [7:0]    x_q;
  logic [PW-1:0] page_q;
  logic [2:0]    bit_q;
  logic          colour_q;
  logic [7:0]    value_q;
  logic [AW-1:0] clr_addr;
  logic          clr_last;

  logic          accept;
  logic          on_panel;
  logic [15:0]   lin;
  logic [AW-1:0] in_addr;
  logic [7:0]    new_byte;
  logic [7:0]    mask;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    out_byte;

  assign cw       = ucode(step);
  assign busy     = (step != ST_IDLE);
  assign accept   = start && !busy;
  assign on_panel = ({1'b0, item.x_coord} < 9'(COLUMNS)) &&
                    ({1'b0, item.y_coord} < 9'(ROWS));
  assign lin      = 16'(item.y_coord[7:3]) * 16'(COLUMNS) + 16'(item.x_coord);
  assign in_addr  = lin[AW-1:0];
  assign clr_last = (clr_addr == AW'(DEPTH - 1));

  assign mask     = 8'b1 << bit_q;
  assign new_byte = colour_q ? (rd_q | mask) : (rd_q & ~mask);
  assign wr_en    = cw.mem_wr || cw.clr_wr;
  assign wr_addr  = cw.clr_wr ? clr_addr : addr_q;
  assign wr_data  = cw.clr_wr ? 8'h00 : new_byte;

  always_comb begin
    step_next = step;
    unique case (cw.cond)
      J_NEXT:  step_next = step + 3'd1;
      J_HOME:  step_next = ST_IDLE;
      J_CLEAR: step_next = clr_last ? ST_IDLE : ST_CLEAR;
      J_WAIT: begin
        if (start) begin
          if (item.action == ACT_CLEAR) begin
            step_next = ST_CLEAR;
          end else if (on_panel) begin
            step_next = ST_WRITE;
          end
        end
      end
    endcase
  end

  always_comb begin
    unique case (cw.sel)
      SEL_PAGE: out_byte = page_base + 8'(page_q);
      SEL_LOW:  out_byte = low_base | {4'h0, x_q[3:0]};
      SEL_HIGH: out_byte = high_base | {4'h0, x_q[7:4]};
      SEL_DATA: out_byte = value_q;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= ST_CLEAR;
      clr_addr  <= '0;
      strobe    <= 1'b0;
      page_base <= 8'd176;
      low_base  <= 8'd0;
      high_base <= 8'd16;
    end else begin
      step   <= step_next;
      strobe <= cw.emit;
      if (cw.clr_wr) begin
        clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_PAGE_BASE: page_base <= cfg_data;
          REG_LOW_BASE:  low_base  <= cfg_data;
          REG_HIGH_BASE: high_base <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_q     <= store[in_addr];
      addr_q   <= in_addr;
      x_q      <= item.x_coord;
      page_q   <= item.y_coord[PW+2:3];
      bit_q    <= item.y_coord[2:0];
      colour_q <= item.colour;
    end
    if (cw.mem_wr) begin
      value_q <= new_byte;
    end
    result.is_data    <= cw.is_data;
    result.byte_value <= out_byte;
    result.last       <= cw.last;
  end

  `PFP_ASSERT_NOW(a_last_is_data, clk, rst, strobe && result.last, result.is_data)
  `PFP_ASSERT_NEXT(a_gap_after_last, clk, rst, strobe && result.last, !strobe)
  `PFP_ASSERT_TWO(a_plot_emits, clk, rst, accept && (item.action == ACT_PLOT) && on_panel, strobe)

endmodule
